@@ hw/rtl/u2ncr_pkg.sv @@
// Shared types, constants and helper functions of the UTF-8 to character reference unit.
`default_nettype none

package u2ncr_pkg;

   // Lead byte classification masks and codes.
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_CODE = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_CODE = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_CODE = 8'hF0;

   // Code point width and the limits used for overlong and surrogate checks.
   localparam int unsigned CODE_BITS = 21;
   localparam logic [CODE_BITS-1:0] MAX_ASCII    = 21'h00007F;
   localparam logic [CODE_BITS-1:0] MAX_TWO      = 21'h0007FF;
   localparam logic [CODE_BITS-1:0] MAX_THREE    = 21'h00FFFF;
   localparam logic [CODE_BITS-1:0] SURR_FIRST   = 21'h00D800;
   localparam logic [CODE_BITS-1:0] SURR_LAST    = 21'h00DFFF;

   // Sequence lengths, counted in continuation bytes.
   localparam logic [1:0] SEQ_TWO   = 2'd1;
   localparam logic [1:0] SEQ_THREE = 2'd2;
   localparam logic [1:0] SEQ_FOUR  = 2'd3;

   // Width of the error count as shown in each response.
   localparam int unsigned SHOWN_BITS = 16;
   localparam logic [31:0] SHOWN_MAX  = 32'h0000FFFF;

   // ASCII characters of the escape text.
   localparam logic [6:0] CH_AMP  = 7'h26;
   localparam logic [6:0] CH_HASH = 7'h23;
   localparam logic [6:0] CH_SEMI = 7'h3B;
   localparam logic [6:0] CH_ZERO = 7'h30;

   // Decimal digit generation: seven digit positions at most, 24-bit multiples.
   localparam int unsigned POS_BITS = 3;
   localparam int unsigned DEC_BITS = 24;

   // Queue between the decoder and the emitter.
   localparam int unsigned QUEUE_DEPTH = 4;

   // What a queued entry asks the emitter to produce.
   typedef enum logic [1:0] {
      KIND_PLAIN,
      KIND_ESCAPE,
      KIND_STATUS
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [CODE_BITS-1:0]    code;
      logic [SHOWN_BITS-1:0]   shown;
   } entry_type;

   // Emitter progress through one escape.
   typedef enum logic [1:0] {
      PH_START,
      PH_HASH,
      PH_DIGIT,
      PH_SEMI
   } phase_type;

   // Power of ten for a digit position.
   function automatic logic [DEC_BITS-1:0] pow10(input logic [POS_BITS-1:0] pos);
      logic [DEC_BITS-1:0] p;
      case (pos)
         3'd0:    p = 24'd1;
         3'd1:    p = 24'd10;
         3'd2:    p = 24'd100;
         3'd3:    p = 24'd1000;
         3'd4:    p = 24'd10000;
         3'd5:    p = 24'd100000;
         3'd6:    p = 24'd1000000;
         default: p = 24'd0;
      endcase
      return p;
   endfunction

   // Digit times power of ten; the digit is always a constant at the call site.
   function automatic logic [DEC_BITS-1:0] dec_multiple(input logic [POS_BITS-1:0] pos,
                                                        input logic [3:0] d);
      logic [DEC_BITS-1:0] p;
      p = pow10(pos);
      return DEC_BITS'(DEC_BITS'(d) * p);
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/u2ncr_front.sv @@
// Decoder front end: gathers UTF-8 sequences, checks them and queues work for the emitter.
`default_nettype none

module u2ncr_front #(
   parameter int unsigned ERROR_COUNT_BITS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic [7:0]          in_byte,
   input  wire logic                end_of_stream,
   output logic                     push,
   output u2ncr_pkg::entry_type     push_entry
);

   logic [1:0]                        pending_ff, pending_in;
   logic [1:0]                        seqlen_ff, seqlen_in;
   logic [u2ncr_pkg::CODE_BITS-1:0]   acc_ff, acc_in;
   logic [ERROR_COUNT_BITS-1:0]       tally_ff, tally_in;
   logic [u2ncr_pkg::CODE_BITS-1:0]   acc_shift;
   logic                              reject;
   logic                              bad;
   logic [31:0]                       tally_wide;

   // Decode one request, decide what is queued and update the saturating error tally.
   always_comb begin
      pending_in = pending_ff;
      seqlen_in  = seqlen_ff;
      acc_in     = acc_ff;
      reject     = 1'b0;
      bad        = 1'b0;
      push       = 1'b0;
      push_entry.kind = u2ncr_pkg::KIND_PLAIN;
      push_entry.code = {14'd0, in_byte[6:0]};
      acc_shift  = {acc_ff[u2ncr_pkg::CODE_BITS-7:0], in_byte[5:0]};
      if (accept) begin
         if (end_of_stream) begin
            // A sequence cut short by the end of the stream is an error.
            reject     = (pending_ff != 2'd0);
            pending_in = 2'd0;
            seqlen_in  = 2'd0;
            acc_in     = '0;
            push       = 1'b1;
            push_entry.kind = u2ncr_pkg::KIND_STATUS;
         end else if (pending_ff == 2'd0) begin
            if (!in_byte[7]) begin
               push = 1'b1;
            end else if ((in_byte & u2ncr_pkg::LEAD2_MASK) == u2ncr_pkg::LEAD2_CODE) begin
               acc_in     = {16'd0, in_byte[4:0]};
               seqlen_in  = u2ncr_pkg::SEQ_TWO;
               pending_in = u2ncr_pkg::SEQ_TWO;
            end else if ((in_byte & u2ncr_pkg::LEAD3_MASK) == u2ncr_pkg::LEAD3_CODE) begin
               acc_in     = {17'd0, in_byte[3:0]};
               seqlen_in  = u2ncr_pkg::SEQ_THREE;
               pending_in = u2ncr_pkg::SEQ_THREE;
            end else if ((in_byte & u2ncr_pkg::LEAD4_MASK) == u2ncr_pkg::LEAD4_CODE) begin
               acc_in     = {18'd0, in_byte[2:0]};
               seqlen_in  = u2ncr_pkg::SEQ_FOUR;
               pending_in = u2ncr_pkg::SEQ_FOUR;
            end else begin
               reject = 1'b1;
            end
         end else begin
            // Continuation byte: only its low six bits are taken.
            acc_in     = acc_shift;
            pending_in = pending_ff - 2'd1;
            if (pending_ff == 2'd1) begin
               if (seqlen_ff == u2ncr_pkg::SEQ_TWO) begin
                  bad = (acc_shift <= u2ncr_pkg::MAX_ASCII);
               end else if (seqlen_ff == u2ncr_pkg::SEQ_THREE) begin
                  bad = (acc_shift <= u2ncr_pkg::MAX_TWO) ||
                        ((acc_shift >= u2ncr_pkg::SURR_FIRST) &&
                         (acc_shift <= u2ncr_pkg::SURR_LAST));
               end else begin
                  bad = (acc_shift <= u2ncr_pkg::MAX_THREE);
               end
               seqlen_in = 2'd0;
               acc_in    = '0;
               reject    = bad;
               push      = !bad;
               push_entry.kind = u2ncr_pkg::KIND_ESCAPE;
               push_entry.code = acc_shift;
            end
         end
      end

      // Saturating error tally and the capped value carried with each entry.
      tally_in = tally_ff;
      if (reject && (tally_ff != '1)) begin
         tally_in = tally_ff + 1'b1;
      end
      tally_wide = 32'(tally_in);
      push_entry.shown = (tally_wide > u2ncr_pkg::SHOWN_MAX) ?
                         u2ncr_pkg::SHOWN_BITS'(u2ncr_pkg::SHOWN_MAX) :
                         tally_wide[u2ncr_pkg::SHOWN_BITS-1:0];
   end

   // Decoder state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
         seqlen_ff  <= 2'd0;
         acc_ff     <= '0;
         tally_ff   <= '0;
      end else begin
         pending_ff <= pending_in;
         seqlen_ff  <= seqlen_in;
         acc_ff     <= acc_in;
         tally_ff   <= tally_in;
      end
   end

   // An escape is only ever queued for a code point beyond ASCII.
   assert property (@(posedge clock) disable iff (reset)
      (push && (push_entry.kind == u2ncr_pkg::KIND_ESCAPE)) |->
         (push_entry.code > u2ncr_pkg::MAX_ASCII))
      else $error("escape queued for an ASCII code point");

   // No sequence is open after an end-of-stream request.
   assert property (@(posedge clock) disable iff (reset)
      (accept && end_of_stream) |=> (pending_ff == 2'd0))
      else $error("sequence left open after end of stream");

endmodule

`default_nettype wire

@@ hw/rtl/u2ncr_queue.sv @@
// Short first-in first-out queue of decoded entries between the decoder and the emitter.
`default_nettype none

module u2ncr_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire u2ncr_pkg::entry_type push_entry,
   input  wire logic                pop,
   output u2ncr_pkg::entry_type     head,
   output logic                     empty,
   output logic                     full
);

   localparam int unsigned PTR_BITS = $clog2(u2ncr_pkg::QUEUE_DEPTH);
   localparam int unsigned CNT_BITS = $clog2(u2ncr_pkg::QUEUE_DEPTH + 1);

   u2ncr_pkg::entry_type  store_ff [u2ncr_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_BITS'(u2ncr_pkg::QUEUE_DEPTH));
   assign head  = store_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage; no reset needed on the payload.
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("push into a full queue");

   assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("pop from an empty queue");

endmodule

`default_nettype wire

@@ hw/rtl/u2ncr_back.sv @@
// Emitter back end: turns queued entries into output bytes, spelling escapes in decimal.
`default_nettype none

module u2ncr_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire u2ncr_pkg::entry_type head,
   input  wire logic                empty,
   output logic                     pop,
   input  wire logic                rsp_ready,
   output logic                     rsp_valid,
   output logic [6:0]               rsp_byte,
   output logic                     rsp_last,
   output logic                     rsp_end,
   output logic [u2ncr_pkg::SHOWN_BITS-1:0] rsp_count
);

   u2ncr_pkg::phase_type                phase_ff, phase_in;
   logic [u2ncr_pkg::CODE_BITS-1:0]     rem_ff, rem_in;
   logic [u2ncr_pkg::POS_BITS-1:0]      pos_ff, pos_in;
   logic                                valid_ff, valid_in;
   logic [6:0]                          byte_ff, byte_in;
   logic                                last_ff, last_in;
   logic                                end_ff, end_in;
   logic [u2ncr_pkg::SHOWN_BITS-1:0]    count_ff, count_in;
   logic                                advance;
   logic                                fire;
   logic [u2ncr_pkg::POS_BITS-1:0]      first_pos;
   logic [3:0]                          digit;
   logic [u2ncr_pkg::DEC_BITS-1:0]      sub;
   logic [u2ncr_pkg::DEC_BITS-1:0]      rem_wide;

   assign advance = !valid_ff || rsp_ready;
   assign fire    = advance && !empty;

   // Position of the leading digit; escaped code points have at least three digits.
   always_comb begin
      first_pos = 3'd2 +
         u2ncr_pkg::POS_BITS'(head.code >= 21'd1000) +
         u2ncr_pkg::POS_BITS'(head.code >= 21'd10000) +
         u2ncr_pkg::POS_BITS'(head.code >= 21'd100000) +
         u2ncr_pkg::POS_BITS'(head.code >= 21'd1000000);
   end

   // One digit per unstalled cycle: largest multiple of the power of ten that fits.
   always_comb begin
      rem_wide = u2ncr_pkg::DEC_BITS'(rem_ff);
      digit    = 4'd0;
      sub      = '0;
      for (int d = 1; d < 10; d++) begin
         if (rem_wide >= u2ncr_pkg::dec_multiple(pos_ff, 4'(d))) begin
            digit = 4'(d);
            sub   = u2ncr_pkg::dec_multiple(pos_ff, 4'(d));
         end
      end
   end

   // Next phase and the byte loaded into the output register.
   always_comb begin
      phase_in = phase_ff;
      rem_in   = rem_ff;
      pos_in   = pos_ff;
      pop      = 1'b0;
      valid_in = advance ? 1'b0 : valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      end_in   = end_ff;
      count_in = count_ff;
      if (fire) begin
         valid_in = 1'b1;
         last_in  = 1'b0;
         end_in   = 1'b0;
         count_in = head.shown;
         case (phase_ff)
            u2ncr_pkg::PH_START: begin
               case (head.kind)
                  u2ncr_pkg::KIND_PLAIN: begin
                     byte_in = head.code[6:0];
                     last_in = 1'b1;
                     pop     = 1'b1;
                  end
                  u2ncr_pkg::KIND_ESCAPE: begin
                     byte_in  = u2ncr_pkg::CH_AMP;
                     rem_in   = head.code;
                     pos_in   = first_pos;
                     phase_in = u2ncr_pkg::PH_HASH;
                  end
                  default: begin
                     byte_in = 7'd0;
                     last_in = 1'b1;
                     end_in  = 1'b1;
                     pop     = 1'b1;
                  end
               endcase
            end
            u2ncr_pkg::PH_HASH: begin
               byte_in  = u2ncr_pkg::CH_HASH;
               phase_in = u2ncr_pkg::PH_DIGIT;
            end
            u2ncr_pkg::PH_DIGIT: begin
               byte_in = u2ncr_pkg::CH_ZERO + {3'd0, digit};
               rem_in  = u2ncr_pkg::CODE_BITS'(rem_wide - sub);
               if (pos_ff == '0) begin
                  phase_in = u2ncr_pkg::PH_SEMI;
               end else begin
                  pos_in = pos_ff - 1'b1;
               end
            end
            u2ncr_pkg::PH_SEMI: begin
               byte_in  = u2ncr_pkg::CH_SEMI;
               last_in  = 1'b1;
               pop      = 1'b1;
               phase_in = u2ncr_pkg::PH_START;
            end
            default: begin
               phase_in = u2ncr_pkg::PH_START;
            end
         endcase
      end
   end

   // Phase register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= u2ncr_pkg::PH_START;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   // Digit work registers and output payload.
   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      pos_ff   <= pos_in;
      byte_ff  <= byte_in;
      last_ff  <= last_in;
      end_ff   <= end_in;
      count_ff <= count_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_byte  = byte_ff;
   assign rsp_last  = last_ff;
   assign rsp_end   = end_ff;
   assign rsp_count = count_ff;

   // An escape in progress always keeps its entry at the head of the queue.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff != u2ncr_pkg::PH_START) |-> !empty)
      else $error("escape in progress with the queue empty");

   // Digit positions never go beyond the seventh digit.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == u2ncr_pkg::PH_DIGIT) |-> (pos_ff <= 3'd6))
      else $error("digit position out of range");

endmodule

`default_nettype wire

@@ hw/rtl/utf8_to_numeric_char_ref_unit.sv @@
// Top level of the UTF-8 to decimal character reference unit.
//
//  Channel  Direction  tdata (low bit up)                      tuser          tlast
//  req_     in         in_byte[7:0]                            end_of_stream  unused
//  rsp_     out        out_byte[6:0], error_count[22:7], 0     stream_end     last_of_run
//
// An ASCII byte or an end-of-stream request yields one output byte; a rejected or partial
// sequence byte yields none. An escape is emitted as '&', '#', its decimal digits and ';';
// the four-entry queue lets the decoder keep taking requests meanwhile.
// Synchronous reset clears the decoder, the queue, the emitter and the error tally.
// req_tready falls only while the queue is full; rsp_tready low holds the output register.
`default_nettype none

module utf8_to_numeric_char_ref_unit #(
   parameter int unsigned ERROR_COUNT_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // in_byte[7:0]
   input  wire logic        req_tuser,    // end_of_stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,    // out_byte[6:0], error_count[22:7], zero pad[23]
   output logic             rsp_tuser,    // stream_end
   output logic             rsp_tlast     // last_of_run
);

   logic                    accept;
   logic                    push;
   u2ncr_pkg::entry_type    push_entry;
   logic                    pop;
   u2ncr_pkg::entry_type    head;
   logic                    empty;
   logic                    full;
   logic [6:0]              out_byte;
   logic [u2ncr_pkg::SHOWN_BITS-1:0] out_count;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   u2ncr_front #(
      .ERROR_COUNT_BITS (ERROR_COUNT_BITS)
   ) front_i (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .in_byte       (req_tdata),
      .end_of_stream (req_tuser),
      .push          (push),
      .push_entry    (push_entry)
   );

   u2ncr_queue queue_i (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   u2ncr_back back_i (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .empty     (empty),
      .pop       (pop),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_byte  (out_byte),
      .rsp_last  (rsp_tlast),
      .rsp_end   (rsp_tuser),
      .rsp_count (out_count)
   );

   assign rsp_tdata = {1'b0, out_count, out_byte};

endmodule

`default_nettype wire
